// ----- hw/rtl/rcop_pkg.sv -----
// shared types, codes and constants of the reference-counted object pool
`timescale 1ns / 1ps

package rcop_pkg;

  localparam int POOL_SLOTS_DEF = 256;
  localparam int COUNT_W        = 32;
  localparam int LINK_W         = 9;
  localparam int IDX_W          = 8;
  localparam int CHUNK_W        = 16;
  localparam int CHUNK_POS_W    = $clog2(CHUNK_W);

  localparam logic [LINK_W-1:0]  NO_PARENT = LINK_W'(256);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_GET    = 2'd1,
    OP_PUT    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_CREATE_WR,
    S_PAR_RD,
    S_PAR_UPD,
    S_TGT_RD,
    S_TGT_EVAL,
    S_FINISH
  } state_t;

  // one slot of the pool
  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] count;
    logic [LINK_W-1:0]  link;
  } slot_rec_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic search_step;
    logic create_write;
    logic read_par;
    logic raise_par;
    logic read_cur;
    logic eval_step;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    op_t  in_op;
    logic in_obj_ok;
    logic search_hit;
    logic search_last;
    logic eval_more;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/rcop_ctrl.sv -----
// sequencing state machine of the object pool
`timescale 1ns / 1ps

module rcop_ctrl import rcop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_stat_t   st,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (st.in_op)
            OP_CREATE: state_next = S_SEARCH;
            OP_GET, OP_PUT: state_next = st.in_obj_ok ? S_TGT_RD : S_FINISH;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SEARCH: begin
        if (st.search_hit) state_next = S_CREATE_WR;
        else if (st.search_last) state_next = S_FINISH;
      end
      S_CREATE_WR: state_next = S_PAR_RD;
      S_PAR_RD:    state_next = S_PAR_UPD;
      S_PAR_UPD:   state_next = S_FINISH;
      S_TGT_RD:    state_next = S_TGT_EVAL;
      S_TGT_EVAL:  state_next = st.eval_more ? S_TGT_RD : S_FINISH;
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_CLEAR:     cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SEARCH:    cmd.search_step  = 1'b1;
      S_CREATE_WR: cmd.create_write = 1'b1;
      S_PAR_RD:    cmd.read_par     = 1'b1;
      S_PAR_UPD:   cmd.raise_par    = 1'b1;
      S_TGT_RD:    cmd.read_cur     = 1'b1;
      S_TGT_EVAL:  cmd.eval_step    = 1'b1;
      S_FINISH:    cmd.emit         = st.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/rcop_dp.sv -----
// slot memory, free-slot bitmap, work registers and output register
`timescale 1ns / 1ps

module rcop_dp import rcop_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           st,
  input  logic [1:0]         in_cmd,
  input  logic [IDX_W-1:0]   object_index,
  input  logic [IDX_W-1:0]   parent_index,
  input  logic               parent_given,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   result_index,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count_after,
  output logic [LINK_W-1:0]  released_count
);

  localparam int SLOT_W      = $clog2(POOL_SLOTS);
  localparam int CW          = (SLOT_W + 1 > LINK_W) ? SLOT_W + 1 : LINK_W;
  localparam int SEARCH_N    = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
  localparam int SRCH_W      = $clog2(SEARCH_N);
  localparam int N_CHUNKS    = (SEARCH_N + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_IDX_W = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;

  localparam logic [CW-1:0]          POOL_LIM   = CW'(POOL_SLOTS);
  localparam logic [CW-1:0]          SEARCH_LIM = CW'(SEARCH_N);
  localparam logic [SLOT_W-1:0]      CLR_LAST   = SLOT_W'(POOL_SLOTS - 1);
  localparam logic [CHUNK_IDX_W-1:0] CHUNK_LAST = CHUNK_IDX_W'(N_CHUNKS - 1);

  localparam slot_rec_t ROOT_REC  = '{active: 1'b1, count: COUNT_W'(1), link: NO_PARENT};
  localparam slot_rec_t EMPTY_REC = '{active: 1'b0, count: '0, link: NO_PARENT};

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

  // slot memory
  slot_rec_t          mem [POOL_SLOTS];
  slot_rec_t          rd;
  slot_rec_t          wdata;
  logic               we, re;
  logic [SLOT_W-1:0]  waddr, raddr;

  // active bits of the searchable slots
  logic [SEARCH_N-1:0]            used;
  logic [N_CHUNKS*CHUNK_W-1:0]    used_pad;
  logic [CHUNK_W-1:0]             chunk;
  logic [CHUNK_IDX_W-1:0]         chunk_idx;
  logic                           hit;
  logic [CHUNK_POS_W-1:0]         pos;
  logic [SLOT_W-1:0]              found;

  // work registers
  logic [SLOT_W-1:0]  clr_idx;
  op_t                op;
  logic [IDX_W-1:0]   par_sel;
  logic [LINK_W-1:0]  cur;
  logic [SLOT_W-1:0]  slot;
  logic               first;
  logic [IDX_W-1:0]   res_idx;
  status_t            res_status;
  logic [COUNT_W-1:0] res_cnt;
  logic [LINK_W-1:0]  res_freed;

  logic [COUNT_W-1:0] cnt_inc, cnt_dec;
  logic               dec_zero, link_ok, cur_srch;
  logic [IDX_W-1:0]   par_next;

  assign cnt_inc  = sat_inc(rd.count);
  assign cnt_dec  = (rd.count == '0) ? rd.count : rd.count - COUNT_W'(1);
  assign dec_zero = (cnt_dec == '0);
  assign link_ok  = CW'(rd.link) < POOL_LIM;
  assign cur_srch = CW'(cur) < SEARCH_LIM;
  assign par_next = (parent_given && (CW'(parent_index) < POOL_LIM)) ? parent_index : '0;

  // lowest free slot within the current chunk
  always_comb begin
    used_pad = '1;
    used_pad[SEARCH_N-1:0] = used;
    chunk = used_pad[{chunk_idx, {CHUNK_POS_W{1'b0}}} +: CHUNK_W];
    hit = 1'b0;
    pos = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        hit = 1'b1;
        pos = CHUNK_POS_W'(i);
      end
    end
    found = SLOT_W'({chunk_idx, pos});
  end

  always_comb begin
    st.clear_last  = (clr_idx == CLR_LAST);
    st.in_op       = op_t'(in_cmd);
    st.in_obj_ok   = CW'(object_index) < POOL_LIM;
    st.search_hit  = hit;
    st.search_last = (chunk_idx == CHUNK_LAST);
    st.eval_more   = (op == OP_PUT) && rd.active && dec_zero && link_ok;
    st.out_free    = !out_valid || !out_stall;
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = SLOT_W'(cur);
    wdata = rd;
    re    = 1'b0;
    raddr = SLOT_W'(cur);
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = (clr_idx == '0) ? ROOT_REC : EMPTY_REC;
    end else if (cmd.create_write) begin
      we    = 1'b1;
      waddr = slot;
      wdata = '{active: 1'b1, count: COUNT_W'(1), link: LINK_W'(par_sel)};
    end else if (cmd.raise_par) begin
      we    = 1'b1;
      waddr = SLOT_W'(par_sel);
      wdata = '{active: rd.active, count: cnt_inc, link: rd.link};
    end else if (cmd.eval_step && rd.active) begin
      we    = 1'b1;
      if (op == OP_GET) begin
        wdata = '{active: 1'b1, count: cnt_inc, link: rd.link};
      end else begin
        wdata = '{active: !dec_zero, count: cnt_dec, link: rd.link};
      end
    end
    if (cmd.read_par) begin
      re    = 1'b1;
      raddr = SLOT_W'(par_sel);
    end else if (cmd.read_cur) begin
      re    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      used      <= SEARCH_N'(1);
      chunk_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_idx <= clr_idx + SLOT_W'(1);
      if (cmd.load) chunk_idx <= '0;
      else if (cmd.search_step && !hit && !st.search_last) chunk_idx <= chunk_idx + 1'b1;
      if (cmd.create_write) used[slot[SRCH_W-1:0]] <= 1'b1;
      if (cmd.eval_step && op == OP_PUT && rd.active && dec_zero && cur_srch) begin
        used[cur[SRCH_W-1:0]] <= 1'b0;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= op_t'(in_cmd);
      par_sel   <= par_next;
      cur       <= LINK_W'(object_index);
      first     <= 1'b1;
      res_idx   <= object_index;
      res_cnt   <= '0;
      res_freed <= '0;
      if ((op_t'(in_cmd) == OP_GET || op_t'(in_cmd) == OP_PUT) && !st.in_obj_ok) begin
        res_status <= ST_NOT_ACTIVE;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.search_step) begin
      if (hit) begin
        slot <= found;
      end else if (st.search_last) begin
        res_status <= ST_EXHAUSTED;
        res_idx    <= '0;
      end
    end
    if (cmd.create_write) begin
      res_idx <= IDX_W'(slot);
      res_cnt <= COUNT_W'(1);
    end
    if (cmd.raise_par && (CW'(par_sel) == CW'(slot))) res_cnt <= cnt_inc;
    if (cmd.eval_step) begin
      first <= 1'b0;
      if (!rd.active) begin
        if (first) res_status <= ST_NOT_ACTIVE;
      end else if (op == OP_GET) begin
        res_cnt <= cnt_inc;
      end else begin
        if (first) res_cnt <= cnt_dec;
        if (dec_zero) begin
          res_freed <= res_freed + LINK_W'(1);
          cur       <= rd.link;
        end
      end
    end
    if (cmd.emit) begin
      result_index   <= res_idx;
      status         <= res_status;
      count_after    <= res_cnt;
      released_count <= res_freed;
    end
  end

endmodule

// ----- hw/rtl/refcounted_object_pool.sv -----
// top level of the reference-counted object pool
`timescale 1ns / 1ps

// Pool of POOL_SLOTS object slots, each holding an active mark, a saturating
// 32-bit reference count and a parent link, all kept in one slot memory with
// registered reads. After reset a clearing pass writes every slot, one per
// cycle, and no beat is taken until the pass is done; slot 0 comes out as the
// active root with count 1. One command is worked on at a time; the next beat
// is taken as soon as the result sits in the output register, even if it is
// still stalled. The unused command and a get or put whose index lies outside
// the pool go straight to the result; get, and a get or put on an inactive
// slot, read and evaluate the target slot once; a put visits the slots of
// its parent chain in turn (each step is a memory read followed by a write);
// create scans the 16-slot groups of the free-slot bitmap up to and including
// the one holding the free slot (at most 16), writes the new slot, then reads
// and raises its parent; a create on an exhausted pool scans every group.
// A result that is ready while the previous result beat is still stalled
// waits until the output register is free.
// Create raises the parent's count whether or not the parent is active; a
// parent index outside the pool falls back to the root.

module refcounted_object_pool import rcop_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [IDX_W-1:0]   object_index,
  input  logic [IDX_W-1:0]   parent_index,
  input  logic               parent_given,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   result_index,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count_after,
  output logic [LINK_W-1:0]  released_count
);

  ctrl_cmd_t ctl;
  dp_stat_t  dst;

  // sequencer: clearing pass, search, read-modify-write steps, result hand-off
  rcop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (dst),
    .cmd      (ctl)
  );

  // slot memory, free-slot bitmap and output register
  rcop_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl),
    .st             (dst),
    .in_cmd         (cmd),
    .object_index   (object_index),
    .parent_index   (parent_index),
    .parent_given   (parent_given),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_index   (result_index),
    .status         (status),
    .count_after    (count_after),
    .released_count (released_count)
  );

endmodule

// ----- hw/rtl/rcop_checker.sv -----
// port-level checks of the object pool and their binding
`timescale 1ns / 1ps

module rcop_checker import rcop_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [IDX_W-1:0]   result_index,
  input logic [1:0]         status,
  input logic [COUNT_W-1:0] count_after,
  input logic [LINK_W-1:0]  released_count
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(count_after))
    else $error("stalled result beat dropped or changed");

  // failures carry no count and free nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EXHAUSTED || status == ST_NOT_ACTIVE)
      |-> count_after == '0 && released_count == '0)
    else $error("failed command reports a count or released slots");

  // exhausted pool reports slot zero
  a_exhaust_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EXHAUSTED |-> result_index == '0)
    else $error("exhausted pool with non-zero slot");

  // the clearing pass holds off commands right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("command taken during clearing pass");

endmodule

bind refcounted_object_pool rcop_checker u_rcop_checker (.*);
